// ===== design/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EMAG_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("emag assertion failed");

// next-cycle implication
`define EMAG_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("emag assertion failed");

`endif

// ===== design/emag_pkg.sv =====
package emag_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int DIV1_STEPS = 54;
   localparam int DIV2_STEPS = 34;
   // input reg, cordic, three rotation stages, two dividers, two gradient stages, output reg
   localparam int LATENCY = CORDIC_STEPS + DIV1_STEPS + DIV2_STEPS + 7;

   localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

   localparam logic signed [32:0] ATAN_UNITS [CORDIC_STEPS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
      33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
      33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
      33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
      33'sd652, 33'sd326, 33'sd163, 33'sd81
   };

   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [32:0] z;
      logic               flip;
   } cordic_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [30:0] divisor;
      logic [63:0] work;
   } div_type;

endpackage

// ===== design/ellipse_margin_and_gradient_top.sv =====
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  point, centre, heading, semi-axes
// rsp_      out        rsp_valid/rsp_stall  margin, gradient, degenerate, saturated
//
// one transaction per cycle sustained while no result waits under rsp_stall
// pipeline depth is set mostly by the 24-cell cordic row and the 54- and 34-cell divider rows
// synchronous reset clears only the valid chain
// the whole pipeline holds while a result waits under rsp_stall; req_stall follows it
module ellipse_margin_and_gradient_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_centre_x,
   input  logic signed [31:0] req_centre_y,
   input  logic [15:0]        req_heading_angle,
   input  logic [30:0]        req_semi_axis_a,
   input  logic [30:0]        req_semi_axis_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_margin,
   output logic signed [31:0] rsp_gradient_x,
   output logic signed [31:0] rsp_gradient_y,
   output logic               rsp_degenerate,
   output logic               rsp_saturated
);

   localparam int NC = emag_pkg::CORDIC_STEPS;
   localparam int N1 = emag_pkg::DIV1_STEPS;
   localparam int N2 = emag_pkg::DIV2_STEPS;
   localparam int LAT = emag_pkg::LATENCY;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [30:0]        a;
      logic [30:0]        b;
      logic               deg;
   } side_a_type;

   typedef struct packed {
      logic signed [30:0] c;
      logic signed [30:0] s;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [30:0]        a;
      logic [30:0]        b;
      logic               deg;
   } rot_type;

   typedef struct packed {
      logic signed [63:0] pcx;
      logic signed [63:0] psy;
      logic signed [63:0] pcy;
      logic signed [63:0] psx;
      logic signed [30:0] c;
      logic signed [30:0] s;
      logic [30:0]        a;
      logic [30:0]        b;
      logic               deg;
   } prod_type;

   typedef struct packed {
      logic [34:0]        magu;
      logic [34:0]        magv;
      logic               upos;
      logic               vpos;
      logic signed [30:0] c;
      logic signed [30:0] s;
      logic [30:0]        a;
      logic [30:0]        b;
      logic               deg;
   } frame_type;

   typedef struct packed {
      logic signed [30:0] c;
      logic signed [30:0] s;
      logic               upos;
      logic               vpos;
      logic               bigu;
      logic               bigv;
      logic               deg;
   } side_d1_type;

   typedef struct packed {
      logic signed [30:0] c;
      logic signed [30:0] s;
      logic               upos;
      logic               vpos;
      logic               gcapu;
      logic               gcapv;
      logic [32:0]        termu;
      logic [32:0]        termv;
      logic               deg;
   } side_d2_type;

   typedef struct packed {
      logic signed [34:0] gu;
      logic signed [34:0] gv;
      logic               hit;
      logic signed [30:0] c;
      logic signed [30:0] s;
      logic [32:0]        termu;
      logic [32:0]        termv;
      logic               deg;
   } grad_type;

   typedef struct packed {
      logic signed [65:0] pgx1;
      logic signed [65:0] pgx2;
      logic signed [65:0] pgy1;
      logic signed [65:0] pgy2;
      logic               hit;
      logic [32:0]        termu;
      logic [32:0]        termv;
      logic               deg;
   } gprod_type;

   function automatic logic [32:0] clip32(input logic signed [38:0] v);
      logic [32:0] r;
      if (v > 39'sd2147483647) begin
         r = {1'b1, 32'h7fffffff};
      end else if (v < -39'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic advance;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign advance = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // input stage: offsets and angle folded into the cordic range
   logic [31:0] z32;
   logic [31:0] zsum;
   logic [31:0] zfold;
   logic        flip;
   emag_pkg::cordic_type cor_s0_ff;
   emag_pkg::cordic_type cor_s0_in;
   side_a_type side_a_ff [NC+1];
   side_a_type side_a_in;

   always_comb begin
      z32 = {req_heading_angle, 16'h0000};
      zsum = z32 + 32'h40000000;
      flip = zsum[31];
      zfold = flip ? (z32 ^ 32'h80000000) : z32;
      cor_s0_in.x = emag_pkg::CORDIC_START;
      cor_s0_in.y = '0;
      cor_s0_in.z = $signed({zfold[31], zfold});
      cor_s0_in.flip = flip;
      side_a_in.dx = 33'(req_point_x) - 33'(req_centre_x);
      side_a_in.dy = 33'(req_point_y) - 33'(req_centre_y);
      side_a_in.a = req_semi_axis_a;
      side_a_in.b = req_semi_axis_b;
      side_a_in.deg = (req_semi_axis_a == '0) || (req_semi_axis_b == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cor_s0_ff <= cor_s0_in;
         side_a_ff[0] <= side_a_in;
         for (int k = 1; k < NC + 1; k++) begin
            side_a_ff[k] <= side_a_ff[k-1];
         end
      end
   end

   emag_pkg::cordic_type cor_q [NC];

   for (genvar k = 0; k < NC; k++) begin : g_cordic
      if (k == 0) begin : g_first
         emag_cordic_cell u_cell (
            .clock      (clock),
            .advance    (advance),
            .step_index (5'(k)),
            .prev_cell  (cor_s0_ff),
            .next_cell  (cor_q[k])
         );
      end else begin : g_rest
         emag_cordic_cell u_cell (
            .clock      (clock),
            .advance    (advance),
            .step_index (5'(k)),
            .prev_cell  (cor_q[k-1]),
            .next_cell  (cor_q[k])
         );
      end
   end

   // r0: undo the fold and round to q2.28
   logic signed [33:0] xe;
   logic signed [33:0] ye;
   logic signed [33:0] xr;
   logic signed [33:0] yr;
   rot_type r0_ff;
   rot_type r0_in;

   always_comb begin
      xe = 34'(cor_q[NC-1].x);
      ye = 34'(cor_q[NC-1].y);
      if (cor_q[NC-1].flip) begin
         xe = -xe;
         ye = -ye;
      end
      xr = xe + 34'sd2;
      yr = ye + 34'sd2;
      r0_in.c = 31'(xr >>> 2);
      r0_in.s = 31'(yr >>> 2);
      r0_in.dx = side_a_ff[NC].dx;
      r0_in.dy = side_a_ff[NC].dy;
      r0_in.a = side_a_ff[NC].a;
      r0_in.b = side_a_ff[NC].b;
      r0_in.deg = side_a_ff[NC].deg;
   end

   // r1: rotation products
   prod_type r1_ff;
   prod_type r1_in;

   always_comb begin
      r1_in.pcx = r0_ff.c * r0_ff.dx;
      r1_in.psy = r0_ff.s * r0_ff.dy;
      r1_in.pcy = r0_ff.c * r0_ff.dy;
      r1_in.psx = r0_ff.s * r0_ff.dx;
      r1_in.c = r0_ff.c;
      r1_in.s = r0_ff.s;
      r1_in.a = r0_ff.a;
      r1_in.b = r0_ff.b;
      r1_in.deg = r0_ff.deg;
   end

   // r2: frame coordinates as magnitude and sign
   logic signed [64:0] sum_u;
   logic signed [64:0] sum_v;
   logic signed [36:0] u_w;
   logic signed [36:0] v_w;
   frame_type r2_ff;
   frame_type r2_in;

   always_comb begin
      sum_u = 65'(r1_ff.pcx) + 65'(r1_ff.psy) + 65'sd134217728;
      sum_v = 65'(r1_ff.pcy) - 65'(r1_ff.psx) + 65'sd134217728;
      u_w = 37'(sum_u >>> 28);
      v_w = 37'(sum_v >>> 28);
      r2_in.magu = u_w[36] ? 35'(-u_w) : 35'(u_w);
      r2_in.magv = v_w[36] ? 35'(-v_w) : 35'(v_w);
      r2_in.upos = !u_w[36] && (u_w != '0);
      r2_in.vpos = !v_w[36] && (v_w != '0);
      r2_in.c = r1_ff.c;
      r2_in.s = r1_ff.s;
      r2_in.a = r1_ff.a;
      r2_in.b = r1_ff.b;
      r2_in.deg = r1_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         r2_ff <= r2_in;
      end
   end

   // first divider row: t = |w| * 2^24 / axis, 54 quotient bits after the overflow test
   emag_pkg::div_type du0;
   emag_pkg::div_type dv0;
   side_d1_type side_d1_ff [N1];
   side_d1_type side_d1_in;

   always_comb begin
      du0.rem = {26'b0, r2_ff.magu[34:30]};
      du0.divisor = r2_ff.a;
      du0.work = {r2_ff.magu[29:0], 34'b0};
      dv0.rem = {26'b0, r2_ff.magv[34:30]};
      dv0.divisor = r2_ff.b;
      dv0.work = {r2_ff.magv[29:0], 34'b0};
      side_d1_in.c = r2_ff.c;
      side_d1_in.s = r2_ff.s;
      side_d1_in.upos = r2_ff.upos;
      side_d1_in.vpos = r2_ff.vpos;
      side_d1_in.bigu = ({26'b0, r2_ff.magu[34:30]} >= r2_ff.a);
      side_d1_in.bigv = ({26'b0, r2_ff.magv[34:30]} >= r2_ff.b);
      side_d1_in.deg = r2_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_d1_ff[0] <= side_d1_in;
         for (int k = 1; k < N1; k++) begin
            side_d1_ff[k] <= side_d1_ff[k-1];
         end
      end
   end

   emag_pkg::div_type du_q [N1];
   emag_pkg::div_type dv_q [N1];

   for (genvar k = 0; k < N1; k++) begin : g_div1
      if (k == 0) begin : g_first
         emag_div_cell u_cell_u (
            .clock (clock), .advance (advance), .prev_cell (du0), .next_cell (du_q[k])
         );
         emag_div_cell u_cell_v (
            .clock (clock), .advance (advance), .prev_cell (dv0), .next_cell (dv_q[k])
         );
      end else begin : g_rest
         emag_div_cell u_cell_u (
            .clock (clock), .advance (advance), .prev_cell (du_q[k-1]), .next_cell (du_q[k])
         );
         emag_div_cell u_cell_v (
            .clock (clock), .advance (advance), .prev_cell (dv_q[k-1]), .next_cell (dv_q[k])
         );
      end
   end

   // second divider row: g = t * 512 / axis, 34 quotient bits; squared terms alongside
   logic [53:0] tu;
   logic [53:0] tv;
   logic        tcapu;
   logic        tcapv;
   logic [63:0] sqru;
   logic [63:0] sqrv;
   emag_pkg::div_type eu0;
   emag_pkg::div_type ev0;
   side_d2_type side_d2_ff [N2];
   side_d2_type side_d2_in;

   always_comb begin
      tu = du_q[N1-1].work[53:0];
      tv = dv_q[N1-1].work[53:0];
      eu0.rem = {2'b0, tu[53:25]};
      eu0.divisor = du_q[N1-1].divisor;
      eu0.work = {tu[24:0], 39'b0};
      ev0.rem = {2'b0, tv[53:25]};
      ev0.divisor = dv_q[N1-1].divisor;
      ev0.work = {tv[24:0], 39'b0};
      tcapu = side_d1_ff[N1-1].bigu || (tu[53:32] != '0);
      tcapv = side_d1_ff[N1-1].bigv || (tv[53:32] != '0);
      sqru = tu[31:0] * tu[31:0];
      sqrv = tv[31:0] * tv[31:0];
      side_d2_in.c = side_d1_ff[N1-1].c;
      side_d2_in.s = side_d1_ff[N1-1].s;
      side_d2_in.upos = side_d1_ff[N1-1].upos;
      side_d2_in.vpos = side_d1_ff[N1-1].vpos;
      side_d2_in.gcapu = side_d1_ff[N1-1].bigu || ({2'b0, tu[53:25]} >= du_q[N1-1].divisor);
      side_d2_in.gcapv = side_d1_ff[N1-1].bigv || ({2'b0, tv[53:25]} >= dv_q[N1-1].divisor);
      side_d2_in.termu = tcapu ? 33'h100000000 : {1'b0, sqru[63:32]};
      side_d2_in.termv = tcapv ? 33'h100000000 : {1'b0, sqrv[63:32]};
      side_d2_in.deg = side_d1_ff[N1-1].deg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_d2_ff[0] <= side_d2_in;
         for (int k = 1; k < N2; k++) begin
            side_d2_ff[k] <= side_d2_ff[k-1];
         end
      end
   end

   emag_pkg::div_type eu_q [N2];
   emag_pkg::div_type ev_q [N2];

   for (genvar k = 0; k < N2; k++) begin : g_div2
      if (k == 0) begin : g_first
         emag_div_cell u_cell_u (
            .clock (clock), .advance (advance), .prev_cell (eu0), .next_cell (eu_q[k])
         );
         emag_div_cell u_cell_v (
            .clock (clock), .advance (advance), .prev_cell (ev0), .next_cell (ev_q[k])
         );
      end else begin : g_rest
         emag_div_cell u_cell_u (
            .clock (clock), .advance (advance), .prev_cell (eu_q[k-1]), .next_cell (eu_q[k])
         );
         emag_div_cell u_cell_v (
            .clock (clock), .advance (advance), .prev_cell (ev_q[k-1]), .next_cell (ev_q[k])
         );
      end
   end

   // f0: capped frame gradient with sign opposite to the coordinate
   logic [33:0] gmagu;
   logic [33:0] gmagv;
   logic [33:0] gclu;
   logic [33:0] gclv;
   logic        hitu;
   logic        hitv;
   grad_type f0_ff;
   grad_type f0_in;

   always_comb begin
      gmagu = eu_q[N2-1].work[33:0];
      gmagv = ev_q[N2-1].work[33:0];
      gclu = (side_d2_ff[N2-1].gcapu || (gmagu > 34'h200000000)) ? 34'h200000000 : gmagu;
      gclv = (side_d2_ff[N2-1].gcapv || (gmagv > 34'h200000000)) ? 34'h200000000 : gmagv;
      hitu = (gclu > 34'h080000000) || (side_d2_ff[N2-1].upos && (gclu == 34'h080000000));
      hitv = (gclv > 34'h080000000) || (side_d2_ff[N2-1].vpos && (gclv == 34'h080000000));
      f0_in.gu = side_d2_ff[N2-1].upos ? -$signed({1'b0, gclu}) : $signed({1'b0, gclu});
      f0_in.gv = side_d2_ff[N2-1].vpos ? -$signed({1'b0, gclv}) : $signed({1'b0, gclv});
      f0_in.hit = hitu || hitv;
      f0_in.c = side_d2_ff[N2-1].c;
      f0_in.s = side_d2_ff[N2-1].s;
      f0_in.termu = side_d2_ff[N2-1].termu;
      f0_in.termv = side_d2_ff[N2-1].termv;
      f0_in.deg = side_d2_ff[N2-1].deg;
   end

   // f1: rotate back, products
   gprod_type f1_ff;
   gprod_type f1_in;

   always_comb begin
      f1_in.pgx1 = f0_ff.c * f0_ff.gu;
      f1_in.pgx2 = f0_ff.s * f0_ff.gv;
      f1_in.pgy1 = f0_ff.s * f0_ff.gu;
      f1_in.pgy2 = f0_ff.c * f0_ff.gv;
      f1_in.hit = f0_ff.hit;
      f1_in.termu = f0_ff.termu;
      f1_in.termv = f0_ff.termv;
      f1_in.deg = f0_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f0_ff <= f0_in;
         f1_ff <= f1_in;
      end
   end

   // f2: sums, clipping, output register
   logic signed [66:0] sgx;
   logic signed [66:0] sgy;
   logic [32:0]        cgx;
   logic [32:0]        cgy;
   logic signed [34:0] mw;
   logic signed [31:0] mclip;
   logic               mhit;
   logic signed [31:0] rsp_margin_ff;
   logic signed [31:0] rsp_margin_in;
   logic signed [31:0] rsp_gradient_x_ff;
   logic signed [31:0] rsp_gradient_x_in;
   logic signed [31:0] rsp_gradient_y_ff;
   logic signed [31:0] rsp_gradient_y_in;
   logic               rsp_degenerate_ff;
   logic               rsp_degenerate_in;
   logic               rsp_saturated_ff;
   logic               rsp_saturated_in;

   always_comb begin
      sgx = 67'(f1_ff.pgx1) - 67'(f1_ff.pgx2) + 67'sd134217728;
      sgy = 67'(f1_ff.pgy1) + 67'(f1_ff.pgy2) + 67'sd134217728;
      cgx = clip32(39'(sgx >>> 28));
      cgy = clip32(39'(sgy >>> 28));
      mw = 35'sd65536 - $signed({2'b0, f1_ff.termu}) - $signed({2'b0, f1_ff.termv});
      mhit = (mw < -35'sd2147483648);
      mclip = mhit ? $signed(32'h80000000) : 32'(mw);
      if (f1_ff.deg) begin
         rsp_margin_in = '0;
         rsp_gradient_x_in = '0;
         rsp_gradient_y_in = '0;
         rsp_degenerate_in = 1'b1;
         rsp_saturated_in = 1'b0;
      end else begin
         rsp_margin_in = mclip;
         rsp_gradient_x_in = $signed(cgx[31:0]);
         rsp_gradient_y_in = $signed(cgy[31:0]);
         rsp_degenerate_in = 1'b0;
         rsp_saturated_in = f1_ff.hit || mhit || cgx[32] || cgy[32];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_margin_ff <= rsp_margin_in;
         rsp_gradient_x_ff <= rsp_gradient_x_in;
         rsp_gradient_y_ff <= rsp_gradient_y_in;
         rsp_degenerate_ff <= rsp_degenerate_in;
         rsp_saturated_ff <= rsp_saturated_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_margin = rsp_margin_ff;
   assign rsp_gradient_x = rsp_gradient_x_ff;
   assign rsp_gradient_y = rsp_gradient_y_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

// ===== design/emag_cordic_cell.sv =====
module emag_cordic_cell (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [4:0]            step_index,
   input  emag_pkg::cordic_type  prev_cell,
   output emag_pkg::cordic_type  next_cell
);

   emag_pkg::cordic_type cell_ff;
   emag_pkg::cordic_type cell_in;

   always_comb begin
      cell_in = prev_cell;
      if (!prev_cell.z[32]) begin
         cell_in.x = prev_cell.x - (prev_cell.y >>> step_index);
         cell_in.y = prev_cell.y + (prev_cell.x >>> step_index);
         cell_in.z = prev_cell.z - emag_pkg::ATAN_UNITS[step_index];
      end else begin
         cell_in.x = prev_cell.x + (prev_cell.y >>> step_index);
         cell_in.y = prev_cell.y - (prev_cell.x >>> step_index);
         cell_in.z = prev_cell.z + emag_pkg::ATAN_UNITS[step_index];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign next_cell = cell_ff;

endmodule

// ===== design/emag_div_cell.sv =====
module emag_div_cell (
   input  logic               clock,
   input  logic               advance,
   input  emag_pkg::div_type  prev_cell,
   output emag_pkg::div_type  next_cell
);

   emag_pkg::div_type cell_ff;
   emag_pkg::div_type cell_in;
   logic [31:0] trial;
   logic [31:0] diff;
   logic        fits;

   // one restoring step: pull the next dividend bit, shift the quotient bit in at the bottom
   always_comb begin
      trial = {prev_cell.rem, prev_cell.work[63]};
      diff = trial - {1'b0, prev_cell.divisor};
      fits = (trial >= {1'b0, prev_cell.divisor});
      cell_in.rem = fits ? diff[30:0] : trial[30:0];
      cell_in.divisor = prev_cell.divisor;
      cell_in.work = {prev_cell.work[62:0], fits};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign next_cell = cell_ff;

endmodule

// ===== design/emag_checker.sv =====
`include "assert_macros.svh"

module emag_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [31:0] req_point_x,
   input logic signed [31:0] req_point_y,
   input logic signed [31:0] req_centre_x,
   input logic signed [31:0] req_centre_y,
   input logic [15:0]        req_heading_angle,
   input logic [30:0]        req_semi_axis_a,
   input logic [30:0]        req_semi_axis_b,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_margin,
   input logic signed [31:0] rsp_gradient_x,
   input logic signed [31:0] rsp_gradient_y,
   input logic               rsp_degenerate,
   input logic               rsp_saturated
);

   // a degenerate ellipse gives an all-zero result
   `EMAG_ASSERT_IMPLY(a_degenerate_zero, clock, reset, rsp_valid && rsp_degenerate,
      rsp_margin == 0 && rsp_gradient_x == 0 && rsp_gradient_y == 0 && !rsp_saturated)

   // the margin never rises above one
   `EMAG_ASSERT_IMPLY(a_margin_max, clock, reset, rsp_valid, rsp_margin <= 32'sd65536)

   // input backpressure only comes from a held result
   `EMAG_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a stalled result holds
   `EMAG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_margin) && $stable(rsp_gradient_x) && $stable(rsp_gradient_y))

endmodule

bind ellipse_margin_and_gradient_top emag_checker u_emag_checker (.*);

// ===== verif/ellipse_margin_and_gradient_top_tb.sv =====
`timescale 1ns / 100ps

module ellipse_margin_and_gradient_top_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 3000;
   localparam logic [63:0] GRAD_CAP = 64'd1 << 33;
   localparam logic [63:0] TERM_CAP = 64'd1 << 32;

   typedef struct {
      logic signed [31:0] px, py, cx, cy;
      logic [15:0]        ang;
      logic [30:0]        a, b;
   } query_type;

   typedef struct {
      logic signed [31:0] margin, gx, gy;
      logic               degen, sat;
   } margin_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_point_x, req_point_y, req_centre_x, req_centre_y;
   logic [15:0]        req_heading_angle;
   logic [30:0]        req_semi_axis_a, req_semi_axis_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_margin, rsp_gradient_x, rsp_gradient_y;
   logic               rsp_degenerate, rsp_saturated;

   margin_type expected_margins[$];
   int      errors = 0;
   int      sent = 0;
   int      received = 0;
   int      saturated_seen = 0;
   int      degenerate_seen = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   ellipse_margin_and_gradient_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_centre_x(req_centre_x), .req_centre_y(req_centre_y),
      .req_heading_angle(req_heading_angle),
      .req_semi_axis_a(req_semi_axis_a), .req_semi_axis_b(req_semi_axis_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_margin(rsp_margin), .rsp_gradient_x(rsp_gradient_x),
      .rsp_gradient_y(rsp_gradient_y), .rsp_degenerate(rsp_degenerate),
      .rsp_saturated(rsp_saturated)
   );

   always #1 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic void heading_sin_cos(input logic [15:0] ang,
                                           output longint c28, output longint s28);
      logic [31:0] z32;
      logic [31:0] probe;
      logic        flip;
      longint      x, y, z, nx;
      z32 = {ang, 16'h0000};
      probe = z32 + 32'h4000_0000;
      flip = probe[31];
      if (flip) z32[31] = ~z32[31];
      z = longint'($signed(z32));
      x = longint'(emag_pkg::CORDIC_START);
      y = 0;
      for (int i = 0; i < emag_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(emag_pkg::ATAN_UNITS[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(emag_pkg::ATAN_UNITS[i]);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c28 = (x + 2) >>> 2;
      s28 = (y + 2) >>> 2;
   endfunction

   function automatic void axis_margin_terms(input longint w, input logic [63:0] axis,
                                             output logic [63:0] term,
                                             output longint grad, inout logic hit);
      logic [63:0] mag, t, g;
      mag = (w < 0) ? -w : w;
      t = (mag << 24) / axis;
      term = (t >= TERM_CAP) ? TERM_CAP : ((t * t) >> 32);
      if (t >= (64'd1 << 54)) begin
         g = GRAD_CAP;
      end else begin
         g = (t * 64'd512) / axis;
         if (g > GRAD_CAP) g = GRAD_CAP;
      end
      if (g > 64'd2147483648) hit = 1'b1;
      if (w > 0 && g == 64'd2147483648) hit = 1'b1;
      grad = (w > 0) ? -longint'(g) : longint'(g);
   endfunction

   function automatic longint clip_q16(input longint v, inout logic hit);
      if (v > 64'sd2147483647) begin
         hit = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         hit = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic margin_type predict_margin(input query_type q);
      margin_type  r;
      longint      c, s, dx, dy, u, v, gu, gv;
      logic [63:0] tu, tv;
      logic        hit;
      hit = 1'b0;
      if (q.a == 0 || q.b == 0) begin
         r.margin = 0; r.gx = 0; r.gy = 0; r.degen = 1'b1; r.sat = 1'b0;
         return r;
      end
      heading_sin_cos(q.ang, c, s);
      dx = longint'(q.px) - longint'(q.cx);
      dy = longint'(q.py) - longint'(q.cy);
      u = (c * dx + s * dy + (64'sd1 <<< 27)) >>> 28;
      v = (c * dy - s * dx + (64'sd1 <<< 27)) >>> 28;
      axis_margin_terms(u, {33'd0, q.a}, tu, gu, hit);
      axis_margin_terms(v, {33'd0, q.b}, tv, gv, hit);
      r.margin = 32'(clip_q16(64'sd65536 - longint'(tu) - longint'(tv), hit));
      r.gx = 32'(clip_q16((c * gu - s * gv + (64'sd1 <<< 27)) >>> 28, hit));
      r.gy = 32'(clip_q16((s * gu + c * gv + (64'sd1 <<< 27)) >>> 28, hit));
      r.degen = 1'b0;
      r.sat = hit;
      return r;
   endfunction

   // ---------------- receiver side ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                  exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      margin_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         received++;
         if (expected_margins.size() == 0) begin
            $display("%0t: result with nothing expected, actual margin %0h", $realtime,
                     rsp_margin);
            errors++;
         end else begin
            e = expected_margins.pop_front();
            check_field("margin", e.margin, rsp_margin);
            check_field("gradient_x", e.gx, rsp_gradient_x);
            check_field("gradient_y", e.gy, rsp_gradient_y);
            check_field("degenerate", 32'(e.degen), 32'(rsp_degenerate));
            check_field("saturated", 32'(e.sat), 32'(rsp_saturated));
            saturated_seen += rsp_saturated;
            degenerate_seen += rsp_degenerate;
         end
      end
   end

   // no transaction on either channel for too long ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $realtime);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------- sender side ----------------

   task automatic send_query(input query_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_point_x       <= q.px;
      req_point_y       <= q.py;
      req_centre_x      <= q.cx;
      req_centre_y      <= q.cy;
      req_heading_angle <= q.ang;
      req_semi_axis_a   <= q.a;
      req_semi_axis_b   <= q.b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_margins.push_back(predict_margin(q));
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_margins.size() != 0) @(posedge clock);
   endtask

   function automatic query_type make_query(input logic signed [31:0] px, py, cx, cy,
                                            input logic [15:0] ang,
                                            input logic [30:0] a, b);
      query_type q;
      q.px = px; q.py = py; q.cx = cx; q.cy = cy; q.ang = ang; q.a = a; q.b = b;
      return q;
   endfunction

   function automatic query_type random_query();
      query_type q;
      int        span;
      if ($urandom_range(9) < 7) begin
         // plausible scene: offsets of a few tens of metres, axes of a few metres
         span = 1 << $urandom_range(22, 12);
         q.cx = $urandom;
         q.cy = $urandom;
         q.px = q.cx + $signed($urandom_range(2 * span)) - span;
         q.py = q.cy + $signed($urandom_range(2 * span)) - span;
         q.a = 31'($urandom_range(1 << 21, 1 << 13));
         q.b = 31'($urandom_range(1 << 21, 1 << 13));
      end else begin
         q.px = $urandom; q.py = $urandom; q.cx = $urandom; q.cy = $urandom;
         q.a = 31'($urandom >> ($urandom_range(31)));
         q.b = 31'($urandom >> ($urandom_range(31)));
      end
      q.ang = 16'($urandom);
      if ($urandom_range(49) == 0) q.a = 0;
      if ($urandom_range(49) == 0) q.b = 0;
      return q;
   endfunction

   // ---------------- tests ----------------

   task automatic test_directed();
      logic [15:0] headings[5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF};
      foreach (headings[i])
         send_query(make_query(32'sd131072, 32'sd65536, 0, 0, headings[i],
                               31'd196608, 31'd65536));
      // zero semi-axis on either side and both
      send_query(make_query(32'sd1000, 32'sd2000, 0, 0, 16'd100, 31'd0, 31'd65536));
      send_query(make_query(32'sd1000, 32'sd2000, 0, 0, 16'd100, 31'd65536, 31'd0));
      send_query(make_query(32'sd1000, 32'sd2000, 0, 0, 16'd100, 31'd0, 31'd0));
      // point at the centre
      send_query(make_query(32'sd5000, -32'sd5000, 32'sd5000, -32'sd5000, 16'd8192,
                            31'd65536, 31'd65536));
      // widest offsets, far outside a tiny ellipse; then a large offset against the largest axes
      send_query(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            16'd0, 31'd1, 31'd1));
      send_query(make_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'd40000, 31'd1, 31'd1));
      send_query(make_query(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'd12345,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
      // huge frame gradient just outside a small ellipse, and far outside a thin one
      send_query(make_query(32'sd300, 32'sd0, 0, 0, 16'd0, 31'd256, 31'd256));
      send_query(make_query(32'sd0, -32'sd300, 0, 0, 16'd0, 31'd256, 31'd256));
      send_query(make_query(32'sd65536, 32'sd0, 0, 0, 16'd0, 31'd16, 31'd1));
      // largest axes, point inside
      send_query(make_query(32'sd65536, 32'sd65536, 0, 0, 16'd3000,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
      // on the boundary and slightly past it
      send_query(make_query(32'sd131072, 0, 0, 0, 16'd0, 31'd131072, 31'd65536));
      send_query(make_query(0, -32'sd65537, 0, 0, 16'd32768, 31'd131072, 31'd65536));
      drain_results();
   endtask

   task automatic test_random_phase(input int n, input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      repeat (n) send_query(random_query());
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_left = LONG_HOLD;
      // pipeline fills under the hold and must stall the request side
      repeat (300) send_query(random_query());
      drain_results();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_point_x <= 0; req_point_y <= 0; req_centre_x <= 0; req_centre_y <= 0;
      req_heading_angle <= 0; req_semi_axis_a <= 0; req_semi_axis_b <= 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(400, 11, 87);
      test_random_phase(400, 87, 11);
      test_random_phase(400, 0, 0);
      test_backpressure();
      repeat (emag_pkg::LATENCY + 20) @(posedge clock);
      $display("covered %0d requests, %0d results, %0d saturated, %0d degenerate",
               sent, received, saturated_seen, degenerate_seen);
      $display("phases: directed corners, three idle mixes, long output hold-off");
      if (errors == 0 && expected_margins.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/emag_pkg.sv
design/emag_cordic_cell.sv
design/emag_div_cell.sv
design/ellipse_margin_and_gradient_top.sv
design/emag_checker.sv
verif/ellipse_margin_and_gradient_top_tb.sv
